// File: src/lcpd_pkg.sv
// Shared types and constants for the line centroid PD steering core.
// No dependencies; used by the channel interfaces, the divider and the top level.
package lcpd_pkg;

   localparam int MASK_W    = 8;
   localparam int TIME_W    = 16;
   localparam int TARGET_W  = 12;
   localparam int LIMIT_W   = 8;
   localparam int DRIVE_W   = 5;
   localparam int STEER_W   = 5;
   localparam int STATUS_W  = 2;
   localparam int ERR_W     = 13;
   localparam int WSUM_W    = 9;   // +-140
   localparam int WTOT_W    = 7;   // up to 100
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_TARGET    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOST_LIMIT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SEGMENT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOST_LEFT_DRIVE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOST_RIGHT_DRV  = 3'd4;

   localparam logic signed [TARGET_W-1:0] RST_TRACK_TARGET = 12'sd0;
   localparam logic [LIMIT_W-1:0]         RST_LOST_LIMIT   = 8'd40;
   localparam logic [TIME_W-1:0]          RST_MIN_SEGMENT  = 16'd3000;
   localparam logic [DRIVE_W-1:0]         RST_LOST_LEFT    = 5'd5;
   localparam logic [DRIVE_W-1:0]         RST_LOST_RIGHT   = 5'd15;

   localparam logic [STATUS_W-1:0] STAT_TRACK = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_LOST  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EXIT  = 2'd2;

   localparam logic [DRIVE_W-1:0] DRIVE_MAX  = 5'd20;
   localparam logic [DRIVE_W-1:0] DRIVE_ZERO = 5'd0;
   localparam logic [LIMIT_W-1:0] LOST_SAT   = 8'd255;

   localparam logic signed [ERR_W-1:0] ERR_HI = 13'sd4095;
   localparam logic signed [ERR_W-1:0] ERR_LO = -13'sd4096;

   // position * weight and weight, indexed by mask bit (bit 7 is position +6)
   localparam logic signed [WSUM_W-1:0] BIT_PW [MASK_W] = '{
      -9'sd60, -9'sd40, -9'sd20, -9'sd20, 9'sd20, 9'sd20, 9'sd40, 9'sd60};
   localparam logic [WTOT_W-1:0] BIT_WT [MASK_W] = '{
      7'd10, 7'd10, 7'd10, 7'd20, 7'd20, 7'd10, 7'd10, 7'd10};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_ERR,
      ST_MIX,
      ST_STEER,
      ST_FIN
   } lcpd_state_type;

endpackage

// File: src/lcpd_ifs.sv
// Valid/ready channel interfaces: sample in, steering result out, register writes.
// Depends on lcpd_pkg for field widths.
interface lcpd_req_if import lcpd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MASK_W-1:0]   sensor_mask;
   logic [TIME_W-1:0]   elapsed_ms;
   logic                restart;

   modport source (output valid, sensor_mask, elapsed_ms, restart, input ready);
   modport sink   (input valid, sensor_mask, elapsed_ms, restart, output ready);
endinterface

interface lcpd_rsp_if import lcpd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [DRIVE_W-1:0]         left_drive;
   logic [DRIVE_W-1:0]         right_drive;
   logic signed [STEER_W-1:0]  steer_correction;
   logic [STATUS_W-1:0]        track_status;

   modport source (output valid, left_drive, right_drive, steer_correction, track_status,
                   input ready);
   modport sink   (input valid, left_drive, right_drive, steer_correction, track_status,
                   output ready);
endinterface

interface lcpd_csr_if import lcpd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DAT_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: src/lcpd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lcpd_pkg for the divisor width.
module lcpd_div import lcpd_pkg::*; #(
   parameter int DW = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DW-1:0]     dividend,
   input  logic [WTOT_W-1:0] divisor,
   output logic              done,
   output logic [DW-1:0]     quotient
);

   localparam int CW = $clog2(DW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [WTOT_W-1:0] rem_ff, rem_in;
   logic [WTOT_W-1:0] dvs_ff, dvs_in;
   logic [DW-1:0]     quo_ff, quo_in;

   logic [WTOT_W:0]   part;
   logic [WTOT_W+1:0] trial;

   always_comb begin
      part    = {rem_ff, quo_ff[DW-1]};
      trial   = {1'b0, part} - {2'b00, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // partial remainder always stays below the divisor, so 7 bits hold it
         if (!trial[WTOT_W+1]) begin
            rem_in = trial[WTOT_W-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = part[WTOT_W-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: src/line_centroid_pd_steering_core.sv
// Line-sensor centroid and PD steering core, top level.
// Depends on lcpd_pkg, the channel interfaces and lcpd_div.
//
// Usage:
//   req_bus carries one sample per beat: sensor_mask, elapsed_ms, restart.
//   rsp_bus returns exactly one beat per sample: left/right drive, the PD
//   steering correction and the track status (tracking, lost, exited).
//   csr_bus writes the five registers (target, lost limit, minimum segment
//   time, lost drives); always ready. User writes only while idle; not enforced.
// Sequencing:
//   A sample with any sensor set runs the centroid through the restoring
//   divider, one quotient bit per cycle, then steps through divider done,
//   error, PD mix, steering and output load; the output load waits while
//   an earlier result is still untaken, and the core then returns to idle.
//   An empty mask or an exited segment skips the divider and goes straight
//   to the output load.
//   req ready is high only while the core is idle, one sample at a time.
// Reset: synchronous, clears lost count, last error, exit flag and loads
//   the register defaults. No memory sweep is needed.
// Stall: the result sits in an output register; a new sample is accepted
//   while it waits, and the next result waits until the first is taken.
module line_centroid_pd_steering_core import lcpd_pkg::*; #(
   parameter int FRACTION_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   lcpd_req_if.sink   req_bus,
   lcpd_rsp_if.source rsp_bus,
   lcpd_csr_if.sink   csr_bus
);

   localparam int DW = WSUM_W - 1 + FRACTION_BITS;           // dividend bits
   localparam int QW = FRACTION_BITS + 4;                    // signed centroid
   localparam int EW = ((QW > TARGET_W) ? QW : TARGET_W) + 1;
   localparam int VW = 20;                                   // PD sum
   localparam int SH = FRACTION_BITS + 2;

   localparam logic signed [EW-1:0] E_HI = EW'(ERR_HI);
   localparam logic signed [EW-1:0] E_LO = EW'(ERR_LO);
   localparam logic signed [VW-1:0] V_BIAS = VW'((1 << SH) - 1);
   localparam logic signed [VW-1:0] P_HI = 20'sd10;
   localparam logic signed [VW-1:0] P_LO = -20'sd10;
   localparam logic signed [5:0] D_MID = 6'sd10;
   localparam logic signed [5:0] D_LO  = 6'sd2;
   localparam logic signed [5:0] D_HI  = 6'sd16;

   lcpd_state_type state_ff, state_in;

   // configuration
   logic signed [TARGET_W-1:0] track_target_ff;
   logic [LIMIT_W-1:0]         lost_limit_ff;
   logic [TIME_W-1:0]          min_segment_ff;
   logic [DRIVE_W-1:0]         lost_left_ff;
   logic [DRIVE_W-1:0]         lost_right_ff;

   // tracking state
   logic signed [ERR_W-1:0] last_error_ff, last_error_in;
   logic [LIMIT_W-1:0]      lost_count_ff, lost_count_in;
   logic                    exited_ff, exited_in;

   // datapath
   logic                    neg_ff, neg_in;
   logic signed [ERR_W-1:0] e_ff, e_in;
   logic signed [VW-1:0]    v_ff, v_in;
   logic [DRIVE_W-1:0]         res_left_ff, res_left_in;
   logic [DRIVE_W-1:0]         res_right_ff, res_right_in;
   logic signed [STEER_W-1:0]  res_steer_ff, res_steer_in;
   logic [STATUS_W-1:0]        res_status_ff, res_status_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [DRIVE_W-1:0]         rsp_left_ff;
   logic [DRIVE_W-1:0]         rsp_right_ff;
   logic signed [STEER_W-1:0]  rsp_steer_ff;
   logic [STATUS_W-1:0]        rsp_status_ff;

   // control
   logic accept, req_ready, track_path, div_start, div_done, rsp_load;
   logic eff_exit;
   logic [LIMIT_W-1:0] eff_lost, lost_inc;
   logic signed [ERR_W-1:0] eff_last;
   logic exit_now;

   // combinational datapath terms
   logic signed [WSUM_W-1:0] wsum;
   logic [WTOT_W-1:0]        wtot;
   logic [WSUM_W-2:0]        wmag;
   logic [DW-1:0]            dividend;
   logic [DW-1:0]            quotient;
   logic [QW-2:0]            cmag;
   logic signed [QW-1:0]     cen;
   logic signed [EW-1:0]     diff;
   logic signed [ERR_W:0]    dlt;
   logic signed [VW-1:0]     ex, dx, vb, pq;
   logic signed [STEER_W-1:0] p;
   logic signed [5:0]        dl, dr;

   assign accept     = req_bus.valid && req_ready;
   assign eff_exit   = exited_ff && !req_bus.restart;
   assign track_path = (req_bus.sensor_mask != '0) && !eff_exit;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = track_path ? ST_DIV : ST_FIN;
         ST_DIV:   if (div_done) state_in = ST_ERR;
         ST_ERR:   state_in = ST_MIX;
         ST_MIX:   state_in = ST_STEER;
         ST_STEER: state_in = ST_FIN;
         ST_FIN:   if (!rsp_valid_ff || rsp_bus.ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      div_start = (state_ff == ST_IDLE) && accept && track_path;
      rsp_load  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_bus.ready);
   end

   lcpd_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (wtot),
      .done     (div_done),
      .quotient (quotient)
   );

   // ---------------- datapath ----------------
   always_comb begin
      wsum = '0;
      wtot = '0;
      for (int b = 0; b < MASK_W; b++) begin
         if (req_bus.sensor_mask[b]) begin
            wsum = wsum + BIT_PW[b];
            wtot = wtot + BIT_WT[b];
         end
      end
      wmag     = (WSUM_W-1)'(wsum[WSUM_W-1] ? -wsum : wsum);
      dividend = {wmag, {FRACTION_BITS{1'b0}}};

      eff_lost = req_bus.restart ? '0 : lost_count_ff;
      eff_last = req_bus.restart ? '0 : last_error_ff;
      lost_inc = (eff_lost == LOST_SAT) ? LOST_SAT : eff_lost + 1'b1;
      exit_now = (lost_inc > lost_limit_ff) && (req_bus.elapsed_ms > min_segment_ff);

      // centroid magnitude fits in FRACTION_BITS+3 bits (at most 6.0)
      cmag = quotient[QW-2:0];
      cen  = neg_ff ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
      diff = EW'(cen) - EW'(track_target_ff);

      dlt = (ERR_W+1)'(e_ff) - (ERR_W+1)'(last_error_ff);
      ex  = VW'(e_ff);
      dx  = VW'(dlt);

      // truncate toward zero: bias negatives before the arithmetic shift
      vb = v_ff[VW-1] ? v_ff + V_BIAS : v_ff;
      pq = vb >>> SH;
      if (pq > P_HI)      p = 5'sd10;
      else if (pq < P_LO) p = -5'sd10;
      else                p = pq[STEER_W-1:0];
      dl = D_MID - 6'(p);
      dr = D_MID + 6'(p);
      if (dl < D_LO) dl = D_LO;
      else if (dl > D_HI) dl = D_HI;
      if (dr < D_LO) dr = D_LO;
      else if (dr > D_HI) dr = D_HI;

      last_error_in = last_error_ff;
      lost_count_in = lost_count_ff;
      exited_in     = exited_ff;
      neg_in        = neg_ff;
      e_in          = e_ff;
      v_in          = v_ff;
      res_left_in   = res_left_ff;
      res_right_in  = res_right_ff;
      res_steer_in  = res_steer_ff;
      res_status_in = res_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_error_in = eff_last;
               lost_count_in = eff_lost;
               exited_in     = eff_exit;
               res_steer_in  = '0;
               if (eff_exit) begin
                  res_left_in   = DRIVE_ZERO;
                  res_right_in  = DRIVE_ZERO;
                  res_status_in = STAT_EXIT;
               end else if (req_bus.sensor_mask == '0) begin
                  lost_count_in = lost_inc;
                  if (exit_now) begin
                     exited_in     = 1'b1;
                     last_error_in = '0;
                     res_left_in   = DRIVE_ZERO;
                     res_right_in  = DRIVE_ZERO;
                     res_status_in = STAT_EXIT;
                  end else begin
                     res_left_in   = (lost_left_ff > DRIVE_MAX) ? DRIVE_MAX : lost_left_ff;
                     res_right_in  = (lost_right_ff > DRIVE_MAX) ? DRIVE_MAX : lost_right_ff;
                     res_status_in = STAT_LOST;
                  end
               end else begin
                  lost_count_in = '0;
                  neg_in        = wsum[WSUM_W-1];
               end
            end
         end
         ST_ERR: begin
            if (diff > E_HI)      e_in = ERR_HI;
            else if (diff < E_LO) e_in = ERR_LO;
            else                  e_in = diff[ERR_W-1:0];
         end
         ST_MIX: begin
            // first nonzero sample after a zero error: 2.5e + 3.5(e/2), times 4
            if ((last_error_ff == '0) && (e_ff != '0))
               v_in = (ex <<< 4) + ex;
            else
               v_in = (ex <<< 3) + (ex <<< 1) + (dx <<< 3) + (dx <<< 2) + (dx <<< 1);
            last_error_in = e_ff;
         end
         ST_STEER: begin
            res_steer_in  = p;
            res_left_in   = dl[DRIVE_W-1:0];
            res_right_in  = dr[DRIVE_W-1:0];
            res_status_in = STAT_TRACK;
         end
         ST_DIV, ST_FIN: ;
         default: ;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (rsp_load)
         rsp_valid_in = 1'b1;
      else if (rsp_bus.ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         track_target_ff <= RST_TRACK_TARGET;
         lost_limit_ff   <= RST_LOST_LIMIT;
         min_segment_ff  <= RST_MIN_SEGMENT;
         lost_left_ff    <= RST_LOST_LEFT;
         lost_right_ff   <= RST_LOST_RIGHT;
         last_error_ff   <= '0;
         lost_count_ff   <= '0;
         exited_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_error_ff <= last_error_in;
         lost_count_ff <= lost_count_in;
         exited_ff     <= exited_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_bus.valid) begin
            unique case (csr_bus.index)
               CSR_TRACK_TARGET:    track_target_ff <= csr_bus.data[TARGET_W-1:0];
               CSR_LOST_LIMIT:      lost_limit_ff   <= csr_bus.data[LIMIT_W-1:0];
               CSR_MIN_SEGMENT:     min_segment_ff  <= csr_bus.data[TIME_W-1:0];
               CSR_LOST_LEFT_DRIVE: lost_left_ff    <= csr_bus.data[DRIVE_W-1:0];
               CSR_LOST_RIGHT_DRV:  lost_right_ff   <= csr_bus.data[DRIVE_W-1:0];
               default: ;
            endcase
         end
      end
      neg_ff        <= neg_in;
      e_ff          <= e_in;
      v_ff          <= v_in;
      res_left_ff   <= res_left_in;
      res_right_ff  <= res_right_in;
      res_steer_ff  <= res_steer_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_left_ff   <= res_left_ff;
         rsp_right_ff  <= res_right_ff;
         rsp_steer_ff  <= res_steer_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign req_bus.ready            = req_ready;
   assign csr_bus.ready            = 1'b1;
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.left_drive       = rsp_left_ff;
   assign rsp_bus.right_drive      = rsp_right_ff;
   assign rsp_bus.steer_correction = rsp_steer_ff;
   assign rsp_bus.track_status     = rsp_status_ff;

   // ---------------- checks ----------------
   a_exit_clears_error: assert property (@(posedge clock) disable iff (reset)
      exited_ff |-> (last_error_ff == '0))
      else $error("exit flag set with nonzero last error");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_track_drive_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STAT_TRACK)) |->
         (rsp_left_ff >= 5'd2) && (rsp_left_ff <= 5'd16) &&
         (rsp_right_ff >= 5'd2) && (rsp_right_ff <= 5'd16))
      else $error("tracking drive outside 2..16");

   a_exit_result_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STAT_TRACK)) |-> (rsp_steer_ff == '0))
      else $error("nonzero steering on a lost or exited beat");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> $stable(rsp_left_ff) && $stable(rsp_steer_ff))
      else $error("pending result overwritten");

endmodule

// File: test/line_centroid_pd_steering_core_tb.sv
// Self-checking testbench for line_centroid_pd_steering_core: directed and random samples,
// a per-sample steering predictor and a result scoreboard.
// Depends on lcpd_pkg, the channel interfaces in lcpd_ifs.sv and the core itself.
`timescale 1ns / 1ps

module line_centroid_pd_steering_core_tb;
   import lcpd_pkg::*;

   localparam int FRAC_BITS   = 8;
   localparam int MAX_CYCLES  = 600000;
   localparam int TIME_MAX    = (1 << TIME_W) - 1;
   localparam int STEER_LIM   = 10;
   localparam int DRIVE_BASE  = 10;
   localparam int TRACK_MIN   = 2;
   localparam int TRACK_MAX   = 16;
   // PD gains scaled by 4: 2.5 on error, 3.5 on change, 4.25 for a first nonzero error
   localparam int GAIN_ERR    = 10;
   localparam int GAIN_DELTA  = 14;
   localparam int GAIN_FIRST  = 17;
   localparam int RUN_ITEMS   = 250;
   localparam int NUM_PHASES  = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd5;

   // sensor position and weight by mask bit, bit 0 is position -6
   localparam int SENSOR_POS [MASK_W] = '{-6, -4, -2, -1, 1, 2, 4, 6};
   localparam int SENSOR_WT  [MASK_W] = '{10, 10, 10, 20, 20, 10, 10, 10};

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic [TIME_W-1:0] elapsed;
      logic              restart;
      logic              drain_first;   // hold until every result is back
   } sample_t;

   typedef struct packed {
      logic [DRIVE_W-1:0]        left;
      logic [DRIVE_W-1:0]        right;
      logic signed [STEER_W-1:0] steer;
      logic [STATUS_W-1:0]       status;
   } steer_res_t;

   typedef enum int {RDY_OPEN, RDY_HALF, RDY_RARE, RDY_SLOW} rdy_mode_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lcpd_req_if req_if ();
   lcpd_rsp_if rsp_if ();
   lcpd_csr_if csr_if ();

   line_centroid_pd_steering_core #(.FRACTION_BITS(FRAC_BITS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow registers and steering state
   logic signed [TARGET_W-1:0] cfg_target     = RST_TRACK_TARGET;
   logic [LIMIT_W-1:0]         cfg_lost_limit = RST_LOST_LIMIT;
   logic [TIME_W-1:0]          cfg_min_time   = RST_MIN_SEGMENT;
   logic [DRIVE_W-1:0]         cfg_lost_left  = RST_LOST_LEFT;
   logic [DRIVE_W-1:0]         cfg_lost_right = RST_LOST_RIGHT;
   logic signed [ERR_W-1:0]    st_last_err    = '0;
   logic [LIMIT_W-1:0]         st_lost_cnt    = '0;
   logic                       st_exited      = 1'b0;

   sample_t    sample_q[$];
   steer_res_t steer_expect_q[$];

   int unsigned beats_in  = 0;
   int unsigned beats_out = 0;
   int          err_cnt   = 0;
   int          cycle_cnt = 0;

   int        gap_left   = 0;
   int        burst_left = 1;
   logic      drv_took;
   logic      drv_go;
   sample_t   drv_item;
   steer_res_t mon_exp;
   rdy_mode_t rdy_mode = RDY_OPEN;
   int        rdy_span = 0;

   function automatic int clamp_int(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic steer_res_t predict_steer(input sample_t s);
      int wsum, wtot, cen, err, mix, p, i;
      steer_res_t r;
      r = '{DRIVE_ZERO, DRIVE_ZERO, '0, STAT_EXIT};
      if (s.restart) begin
         st_lost_cnt = '0;
         st_last_err = '0;
         st_exited   = 1'b0;
      end
      if (st_exited) return r;
      if (s.mask == '0) begin
         if (st_lost_cnt != LOST_SAT) st_lost_cnt++;
         if (st_lost_cnt > cfg_lost_limit && s.elapsed > cfg_min_time) begin
            st_exited   = 1'b1;
            st_last_err = '0;
            return r;
         end
         r.left   = (cfg_lost_left > DRIVE_MAX) ? DRIVE_MAX : cfg_lost_left;
         r.right  = (cfg_lost_right > DRIVE_MAX) ? DRIVE_MAX : cfg_lost_right;
         r.status = STAT_LOST;
         return r;
      end
      st_lost_cnt = '0;
      wsum = 0;
      wtot = 0;
      for (i = 0; i < MASK_W; i++) begin
         if (s.mask[i]) begin
            wsum += SENSOR_POS[i] * SENSOR_WT[i];
            wtot += SENSOR_WT[i];
         end
      end
      cen = (wsum * (1 << FRAC_BITS)) / wtot;
      err = clamp_int(cen - int'(cfg_target), int'(ERR_LO), int'(ERR_HI));
      if (st_last_err == '0 && err != 0)
         mix = GAIN_FIRST * err;
      else
         mix = GAIN_ERR * err + GAIN_DELTA * (err - int'(st_last_err));
      p = clamp_int(mix / (1 << (FRAC_BITS + 2)), -STEER_LIM, STEER_LIM);
      st_last_err = ERR_W'(err);
      r.left   = DRIVE_W'(clamp_int(DRIVE_BASE - p, TRACK_MIN, TRACK_MAX));
      r.right  = DRIVE_W'(clamp_int(DRIVE_BASE + p, TRACK_MIN, TRACK_MAX));
      r.steer  = STEER_W'(p);
      r.status = STAT_TRACK;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [4:0] want,
                                       input logic [4:0] got, input bit signed_fld);
      if (got !== want) begin
         err_cnt++;
         if (signed_fld)
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         else
            $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   function automatic logic [MASK_W-1:0] rand_line_mask();
      logic [MASK_W-1:0] m;
      int w;
      if ($urandom_range(0, 3) == 0) begin
         do m = MASK_W'($urandom); while (m == '0);
      end else begin
         w = $urandom_range(1, 3);
         m = MASK_W'(((1 << w) - 1) << $urandom_range(0, MASK_W - w));
      end
      return m;
   endfunction

   function automatic logic [TIME_W-1:0] advance_time(input logic [TIME_W-1:0] t,
                                                      input int stride);
      int nt;
      nt = int'(t) + int'($urandom_range(0, 2 * stride));
      return (nt > TIME_MAX) ? TIME_W'(TIME_MAX) : TIME_W'(nt);
   endfunction

   function automatic void push_item(input logic [MASK_W-1:0] m, input logic [TIME_W-1:0] el,
                                     input logic rs, input logic dr);
      sample_q.push_back('{m, el, rs, dr});
   endfunction

   // restarts, tracking runs, lost runs up to and past the limit, and random single samples
   task automatic queue_track_run(input int n_items);
      int made, run, k, stride;
      logic [TIME_W-1:0] t;
      made   = 0;
      t      = '0;
      stride = int'(cfg_min_time) / 24 + 1;
      while (made < n_items) begin
         case ($urandom_range(0, 9))
            0: begin
               push_item(MASK_W'($urandom), TIME_W'($urandom), $urandom_range(0, 7) == 0,
                         $urandom_range(0, 99) == 0);
               made++;
            end
            1: begin
               t = '0;
               push_item(($urandom_range(0, 3) == 0) ? '0 : rand_line_mask(), t, 1'b1,
                         $urandom_range(0, 99) == 0);
               made++;
            end
            2, 3, 4: begin
               if ($urandom_range(0, 3) == 0)
                  run = int'(cfg_lost_limit) + int'($urandom_range(1, 4));
               else
                  run = $urandom_range(1, 6);
               for (k = 0; k < run; k++) begin
                  t = advance_time(t, stride);
                  push_item('0, t, 1'b0, $urandom_range(0, 99) == 0);
               end
               made += run;
            end
            default: begin
               run = $urandom_range(1, 12);
               for (k = 0; k < run; k++) begin
                  t = advance_time(t, stride);
                  push_item(rand_line_mask(), t, 1'b0, $urandom_range(0, 99) == 0);
               end
               made += run;
            end
         endcase
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      csr_if.valid <= 1'b0;
      case (idx)
         CSR_TRACK_TARGET:    cfg_target     = val[TARGET_W-1:0];
         CSR_LOST_LIMIT:      cfg_lost_limit = val[LIMIT_W-1:0];
         CSR_MIN_SEGMENT:     cfg_min_time   = val[TIME_W-1:0];
         CSR_LOST_LEFT_DRIVE: cfg_lost_left  = val[DRIVE_W-1:0];
         CSR_LOST_RIGHT_DRV:  cfg_lost_right = val[DRIVE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input int tgt, input int lim, input int min_t,
                            input int left, input int right);
      write_reg(CSR_TRACK_TARGET, 16'(tgt));
      write_reg(CSR_LOST_LIMIT, 16'(lim));
      write_reg(CSR_MIN_SEGMENT, 16'(min_t));
      write_reg(CSR_LOST_LEFT_DRIVE, 16'(left));
      write_reg(CSR_LOST_RIGHT_DRV, 16'(right));
   endtask

   task automatic wait_idle();
      do @(negedge clock); while (sample_q.size() != 0 || steer_expect_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // sample driver: bursts and gaps, valid held until the beat is taken
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left   = 0;
         burst_left = 1;
      end else begin
         drv_took = req_if.valid && req_if.ready;
         if (drv_took) begin
            drv_item = sample_q.pop_front();
            steer_expect_q.push_back(predict_steer(drv_item));
            beats_in <= beats_in + 1;
         end
         if (!req_if.valid || drv_took) begin
            drv_go = 1'b0;
            if (gap_left > 0)
               gap_left--;
            else if (sample_q.size() != 0)
               drv_go = !sample_q[0].drain_first || (!drv_took && beats_in == beats_out);
            if (drv_go) begin
               req_if.sensor_mask <= sample_q[0].mask;
               req_if.elapsed_ms  <= sample_q[0].elapsed;
               req_if.restart     <= sample_q[0].restart;
               burst_left--;
               if (burst_left <= 0) begin
                  if ($urandom_range(0, 7) == 0) begin
                     gap_left   = 0;
                     burst_left = $urandom_range(40, 120);
                  end else begin
                     gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                     burst_left = $urandom_range(1, 16);
                  end
               end
            end
            req_if.valid <= drv_go;
         end
      end
   end

   // result monitor and receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rdy_span = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            beats_out <= beats_out + 1;
            if (steer_expect_q.size() == 0) begin
               err_cnt++;
               $error("result beat with no sample outstanding");
            end else begin
               mon_exp = steer_expect_q.pop_front();
               check_field("left_drive", mon_exp.left, rsp_if.left_drive, 1'b0);
               check_field("right_drive", mon_exp.right, rsp_if.right_drive, 1'b0);
               check_field("steer_correction", mon_exp.steer, rsp_if.steer_correction, 1'b1);
               check_field("track_status", 5'(mon_exp.status), 5'(rsp_if.track_status), 1'b0);
            end
         end
         if (rdy_span == 0) begin
            rdy_mode = rdy_mode_t'($urandom_range(0, 3));
            rdy_span = $urandom_range(64, 200);
         end else begin
            rdy_span--;
         end
         case (rdy_mode)
            RDY_OPEN: rsp_if.ready <= 1'b1;
            RDY_HALF: rsp_if.ready <= $urandom_range(0, 1) == 1;
            RDY_RARE: rsp_if.ready <= $urandom_range(0, 7) != 0;
            default:  rsp_if.ready <= $urandom_range(0, 5) == 0;
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > MAX_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int ph;
      req_if.valid       = 1'b0;
      req_if.sensor_mask = '0;
      req_if.elapsed_ms  = '0;
      req_if.restart     = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.index       = '0;
      csr_if.data        = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // register defaults: centered, edge sensors, center pair, lost, restart
      @(negedge clock);
      push_item(8'hFF, 16'd0, 1'b0, 1'b0);
      push_item(8'h80, 16'd100, 1'b0, 1'b0);
      push_item(8'h01, 16'd200, 1'b0, 1'b0);
      push_item(8'h18, 16'd300, 1'b0, 1'b1);
      push_item(8'h10, 16'd400, 1'b0, 1'b0);
      push_item(8'h08, 16'd500, 1'b0, 1'b0);
      push_item(8'h81, 16'd600, 1'b0, 1'b0);
      push_item(8'h55, 16'd700, 1'b0, 1'b0);
      push_item(8'hAA, 16'd800, 1'b0, 1'b0);
      push_item(8'h00, 16'hFFFF, 1'b0, 1'b0);
      push_item(8'h00, 16'hFFFF, 1'b1, 1'b0);
      push_item(8'h7E, 16'd0, 1'b0, 1'b0);
      wait_idle();

      // target at max, zero limits: exit, hold while exited, restart into exit and tracking
      write_all(1536, 0, 0, 31, 0);
      write_reg(CSR_UNMAPPED, 16'hFFFF);
      @(negedge clock);
      push_item(8'h01, 16'd0, 1'b1, 1'b0);
      push_item(8'h00, 16'd0, 1'b0, 1'b0);
      push_item(8'h00, 16'd1, 1'b0, 1'b0);
      push_item(8'hFF, 16'd2, 1'b0, 1'b0);
      push_item(8'h00, 16'd1, 1'b1, 1'b0);
      push_item(8'h80, 16'd0, 1'b1, 1'b0);
      push_item(8'h01, 16'd0, 1'b0, 1'b0);
      wait_idle();

      // target at min, lost limit 255 never exits
      write_all(-1536, 255, 0, 20, 21);
      @(negedge clock);
      push_item(8'h80, 16'd0, 1'b1, 1'b0);
      push_item(8'h01, 16'd5, 1'b0, 1'b0);
      push_item(8'h00, 16'hFFFF, 1'b0, 1'b0);
      push_item(8'h00, 16'hFFFF, 1'b0, 1'b0);
      wait_idle();

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: write_all(int'(RST_TRACK_TARGET), int'(RST_LOST_LIMIT), int'(RST_MIN_SEGMENT),
                         int'(RST_LOST_LEFT), int'(RST_LOST_RIGHT));
            1: write_all(1536, 0, 0, 0, 20);
            2: write_all(-1536, 254, 0, 31, 21);
            3: write_all(int'($urandom_range(0, 3072)) - 1536, 255, 100, 20, 0);
            4: write_all(-1, 3, 65534, $urandom_range(0, 31), $urandom_range(0, 31));
            default: write_all(int'($urandom_range(0, 3072)) - 1536, $urandom_range(0, 10),
                               $urandom_range(0, 2000), $urandom_range(0, 31),
                               $urandom_range(0, 31));
         endcase
         if (ph >= 4) write_reg(CSR_UNMAPPED + 3'($urandom_range(0, 2)), 16'($urandom));
         @(negedge clock);
         queue_track_run(RUN_ITEMS);
         wait_idle();
      end

      repeat (40) @(posedge clock);
      if (err_cnt == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: files.f
src/lcpd_pkg.sv
src/lcpd_ifs.sv
src/lcpd_div.sv
src/line_centroid_pd_steering_core.sv
test/line_centroid_pd_steering_core_tb.sv
